// ----- rtl/kbc_pkg.sv -----
package kbc_pkg;

	localparam int unsigned BLOCK_W = 32;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned ROUND_CNT_W = 10;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CELL_IDX_W = 11;
	localparam int unsigned MAX_ROUNDS_DEF = 528;
	localparam int unsigned DEC_ROUNDS = 528;
	localparam logic [31:0] NLF_TABLE = 32'h3A5C742E;
	localparam logic [ROUND_CNT_W-1:0] ROUND_COUNT_RST = ROUND_CNT_W'(528);

	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 1'b1;

	typedef struct packed {
		logic                func;
		logic [BLOCK_W-1:0]  block;
	} kbc_word_t;

	function automatic logic [BLOCK_W-1:0] kbc_enc_round(
		input logic [BLOCK_W-1:0] x,
		input logic               k
	);
		logic [4:0] idx;
		logic       nb;
		idx = {x[31], x[26], x[20], x[9], x[1]};
		nb = NLF_TABLE[idx] ^ x[16] ^ x[0] ^ k;
		return {nb, x[BLOCK_W-1:1]};
	endfunction

	function automatic logic [BLOCK_W-1:0] kbc_dec_round(
		input logic [BLOCK_W-1:0] x,
		input logic               k
	);
		logic [4:0] idx;
		logic       nb;
		idx = {x[30], x[25], x[19], x[8], x[0]};
		nb = NLF_TABLE[idx] ^ x[15] ^ x[31] ^ k;
		return {x[BLOCK_W-2:0], nb};
	endfunction

endpackage

// ----- rtl/kbc_round_cell.sv -----
module kbc_round_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned MAX_ROUNDS = kbc_pkg::MAX_ROUNDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic [kbc_pkg::KEY_W-1:0]           cipher_key,
	input  logic [kbc_pkg::ROUND_CNT_W-1:0]     round_count,
	input  logic                                valid_in,
	input  kbc_pkg::kbc_word_t                  word_in,
	output logic                                valid_out,
	output kbc_pkg::kbc_word_t                  word_out
);
	import kbc_pkg::*;

	localparam bit ENC_ACTIVE = (INDEX < MAX_ROUNDS);
	localparam bit DEC_ACTIVE = (INDEX < DEC_ROUNDS);
	localparam int unsigned ENC_KEY_IDX = INDEX % KEY_W;
	localparam int unsigned DEC_KEY_IDX = (KEY_W + 15 - (INDEX % KEY_W)) % KEY_W;
	localparam logic [CELL_IDX_W-1:0] IDX = CELL_IDX_W'(INDEX);

	logic               valid_q;
	kbc_word_t          word_q;
	logic               enc_en;
	logic [BLOCK_W-1:0] block_nxt;

	assign enc_en = ENC_ACTIVE && ({1'b0, round_count} > IDX);

	always_comb begin
		block_nxt = word_in.block;
		if (word_in.func) begin
			if (DEC_ACTIVE) begin
				block_nxt = kbc_dec_round(word_in.block, cipher_key[DEC_KEY_IDX]);
			end
		end else if (enc_en) begin
			block_nxt = kbc_enc_round(word_in.block, cipher_key[ENC_KEY_IDX]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q.func <= word_in.func;
			word_q.block <= block_nxt;
		end
	end

	assign valid_out = valid_q;
	assign word_out = word_q;

endmodule

// ----- rtl/kbc_out_buf.sv -----
module kbc_out_buf (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tail_valid,
	input  logic [kbc_pkg::BLOCK_W-1:0]   tail_block,
	output logic                          adv,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [kbc_pkg::BLOCK_W-1:0]   block_out
);
	import kbc_pkg::*;

	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_block_q;
	logic               skid_valid_q;
	logic [BLOCK_W-1:0] skid_block_q;
	logic               push;
	logic               out_free;

	assign adv = !skid_valid_q;
	assign push = tail_valid && adv;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q || push;
				skid_valid_q <= 1'b0;
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_block_q <= skid_valid_q ? skid_block_q : tail_block;
		end else if (push) begin
			skid_block_q <= tail_block;
		end
	end

	assign out_valid = out_valid_q;
	assign block_out = out_block_q;

	skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid word held while output register is empty.");

	skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		push && out_valid_q && !out_ready |=> skid_valid_q)
		else $error("Word from the chain was lost during an output stall.");

	skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> out_valid_q && !skid_valid_q)
		else $error("Skid word did not move to the output register.");

endmodule

// ----- rtl/keeloq_block_cipher_top.sv -----
// Latency: a word accepted at the input passes through max(MAX_ROUNDS, 528) round cells
// (528 by default), one round cell per round, then the output register, before it appears on block_out.
// Throughput: one word per cycle; the round chain takes a new word every cycle unless the skid register is full.
// A stalled output parks one word in a skid register; the chain then holds until it drains.
// Reset empties the chain and the output, loads cipher_key with zero and round_count
// with 528; no clearing pass is needed.
module keeloq_block_cipher_top #(
	parameter int unsigned MAX_ROUNDS = kbc_pkg::MAX_ROUNDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [kbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kbc_pkg::KEY_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic [kbc_pkg::BLOCK_W-1:0]        block_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [kbc_pkg::BLOCK_W-1:0]        block_out
);
	import kbc_pkg::*;

	localparam int unsigned NUM_CELLS = (MAX_ROUNDS > DEC_ROUNDS) ? MAX_ROUNDS : DEC_ROUNDS;

	logic [KEY_W-1:0]       cipher_key_q;
	logic [ROUND_CNT_W-1:0] round_count_q;
	logic                   adv;
	logic                   chain_valid [0:NUM_CELLS];
	kbc_word_t              chain_word [0:NUM_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q <= '0;
			round_count_q <= ROUND_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CIPHER_KEY: cipher_key_q <= cfg_data;
				REG_ROUND_COUNT: round_count_q <= cfg_data[ROUND_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = adv;
	assign chain_valid[0] = in_valid;
	assign chain_word[0].func = func;
	assign chain_word[0].block = block_in;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		kbc_round_cell #(
			.INDEX      (i),
			.MAX_ROUNDS (MAX_ROUNDS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.cipher_key  (cipher_key_q),
			.round_count (round_count_q),
			.valid_in    (chain_valid[i]),
			.word_in     (chain_word[i]),
			.valid_out   (chain_valid[i+1]),
			.word_out    (chain_word[i+1])
		);
	end

	kbc_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail_valid (chain_valid[NUM_CELLS]),
		.tail_block (chain_word[NUM_CELLS].block),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.block_out  (block_out)
	);

	chain_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(chain_valid[NUM_CELLS]))
		else $error("Round chain moved while the output side was full.");

	first_cell_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> chain_valid[1])
		else $error("Accepted word did not enter the first round cell.");

	tail_kept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[NUM_CELLS] && !adv |=> chain_valid[NUM_CELLS])
		else $error("Word at the end of the chain vanished during a stall.");

endmodule

// ----- dv/keeloq_block_cipher_top_tb.sv -----
`timescale 1ns / 1ps

module keeloq_block_cipher_top_tb;
	import kbc_pkg::*;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = MAX_ROUNDS_DEF + 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CIPHER_KEY;
	logic [KEY_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic [BLOCK_W-1:0] block_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [BLOCK_W-1:0] block_out;

	logic [KEY_W-1:0] key_copy = '0;
	logic [ROUND_CNT_W-1:0] rounds_copy = ROUND_COUNT_RST;
	kbc_word_t words_pending[$];
	logic [BLOCK_W-1:0] blocks_due[$];
	int unsigned words_queued = 0;
	int unsigned words_taken = 0;
	int unsigned blocks_checked = 0;
	int unsigned errors = 0;
	int unsigned idle_cycles = 0;
	int unsigned settings_used = 1;
	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	bit word_taken = 1'b0;

	keeloq_block_cipher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.block_in(block_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.block_out(block_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [BLOCK_W-1:0] cipher_enc(
		input logic [BLOCK_W-1:0] x,
		input logic [KEY_W-1:0]   k,
		input int unsigned        n
	);
		logic [4:0] sel;
		logic       fb;
		for (int unsigned r = 0; r < n; r++) begin
			sel = {x[31], x[26], x[20], x[9], x[1]};
			fb = NLF_TABLE[sel] ^ x[16] ^ x[0] ^ k[r % KEY_W];
			x = x >> 1;
			x[31] = fb;
		end
		return x;
	endfunction

	function automatic logic [BLOCK_W-1:0] cipher_dec(
		input logic [BLOCK_W-1:0] x,
		input logic [KEY_W-1:0]   k
	);
		logic [4:0] sel;
		logic [5:0] kidx;
		logic       fb;
		for (int r = 0; r < int'(DEC_ROUNDS); r++) begin
			sel = {x[30], x[25], x[19], x[8], x[0]};
			kidx = 6'(15 - r);
			fb = NLF_TABLE[sel] ^ x[15] ^ x[31] ^ k[kidx];
			x = x << 1;
			x[0] = fb;
		end
		return x;
	endfunction

	function automatic int unsigned enc_rounds();
		return (rounds_copy > MAX_ROUNDS_DEF) ? MAX_ROUNDS_DEF : rounds_copy;
	endfunction

	function automatic logic [BLOCK_W-1:0] predict_block(input kbc_word_t w);
		if (w.func)
			return cipher_dec(w.block, key_copy);
		else
			return cipher_enc(w.block, key_copy, enc_rounds());
	endfunction

	always @(posedge clk) begin
		word_taken = arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			blocks_due.push_back(predict_block({func, block_in}));
			words_taken++;
		end
	end

	always @(negedge clk) begin : drive_words
		kbc_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || word_taken) begin
			if (words_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				w = words_pending.pop_front();
				in_valid <= 1'b1;
				func <= w.func;
				block_in <= w.block;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin : check_blocks
		logic [BLOCK_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (blocks_due.size() == 0) begin
				$error("block_out: expected no word, actual %h", block_out);
				errors++;
			end else begin
				want = blocks_due.pop_front();
				if (block_out !== want) begin
					$error("block_out: expected %h, actual %h", want, block_out);
					errors++;
				end
			end
			blocks_checked++;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timed out with %0d words outstanding.", blocks_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(input logic f, input logic [BLOCK_W-1:0] b);
		words_pending.push_back({f, b});
		words_queued++;
	endtask

	task automatic drain();
		while (words_taken != words_queued || blocks_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_CIPHER_KEY)
			key_copy = val;
		else
			rounds_copy = val[ROUND_CNT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_cipher(input logic [KEY_W-1:0] key, input int unsigned rounds);
		drain();
		write_reg(REG_CIPHER_KEY, key);
		write_reg(REG_ROUND_COUNT, KEY_W'(rounds));
		settings_used++;
	endtask

	// Most random traffic is encrypt-then-decrypt pairs: a block, then its ciphertext.
	task automatic random_phase(input int unsigned n);
		int unsigned k;
		logic [BLOCK_W-1:0] b;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0: begin
					b = $urandom_range(1) ? '1 : '0;
					send(1'($urandom_range(1)), b);
					k++;
				end
				1, 2, 3, 4: begin
					b = $urandom();
					send(1'b0, b);
					send(1'b1, cipher_enc(b, key_copy, enc_rounds()));
					k += 2;
				end
				default: begin
					send(1'($urandom_range(1)), $urandom());
					k++;
				end
			endcase
		end
	endtask

	initial begin : stimulus
		int unsigned src_pct[4] = '{0, 60, 0, 38};
		int unsigned snk_pct[4] = '{0, 0, 60, 38};
		int unsigned rounds;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(1'b0, 32'h0000_0000);
		send(1'b1, 32'h0000_0000);
		send(1'b0, 32'hFFFF_FFFF);
		send(1'b1, 32'hFFFF_FFFF);
		send(1'b0, 32'h0000_0001);
		send(1'b1, 32'h0000_0001);
		send(1'b0, 32'h8000_0000);
		send(1'b1, 32'h8000_0000);

		// With zero rounds, encryption passes the block through untouched.
		set_cipher(64'h5CEC_6701_B79F_D949, 0);
		send(1'b0, 32'hA5A5_A5A5);
		send(1'b0, 32'hFFFF_FFFF);
		send(1'b1, 32'h1234_5678);

		// Round counts beyond the chain length saturate at the chain length.
		set_cipher('1, 1023);
		send(1'b0, 32'h0000_0000);
		send(1'b0, 32'hDEAD_BEEF);
		send(1'b1, 32'hDEAD_BEEF);
		set_cipher(64'h0123_4567_89AB_CDEF, 529);
		send(1'b0, 32'h0F0F_0F0F);

		set_cipher(64'h8000_0000_0000_0001, 1);
		send(1'b0, 32'h8000_0001);
		send(1'b0, 32'h7FFF_FFFE);
		send(1'b1, 32'h0000_0001);

		for (int p = 0; p < 8; p++) begin
			if (p % 2 == 0) begin
				rounds = 528;
			end else begin
				case (p / 2)
					0: rounds = $urandom_range(1, 527);
					1: rounds = $urandom_range(529, 1023);
					2: rounds = 0;
					default: rounds = $urandom_range(0, 1023);
				endcase
			end
			set_cipher({$urandom(), $urandom()}, rounds);
			@(posedge clk);
			src_idle_pct = src_pct[p / 2];
			snk_stall_pct = snk_pct[p / 2];
			random_phase(80);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d of %0d encrypt and decrypt words over %0d key and round settings.",
			blocks_checked, words_taken, settings_used);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
